/* rtl/core/fftm_pkg.sv */
// ----------------------------------------------------------------------------
// fftm_pkg: shared definitions of the FFT magnitude spectrum core
// Sizes, opcodes, sequencer states, twiddle table builder and datapath helpers.
// ----------------------------------------------------------------------------
package fftm_pkg;

    localparam int POINTS       = 1024;
    localparam int LOG_POINTS   = 10;
    localparam int SAMPLE_BITS  = 16;
    localparam int TWIDDLE_BITS = 16;

    localparam int ADDR_W  = LOG_POINTS;
    localparam int HALF    = POINTS / 2;
    localparam int BF_W    = LOG_POINTS - 1;
    localparam int STAGE_W = 4;
    localparam int BIN_W   = 9;
    localparam int MAG_W   = 26;
    localparam int WORK_W  = 27;
    localparam int ENTRY_W = 2 * WORK_W;
    localparam int PROD_W  = 2 * WORK_W;
    localparam int TR_W    = WORK_W + 2;
    localparam int SQ_IN_W = 2 * MAG_W;
    localparam int SQ_ITER = MAG_W;
    localparam int SQ_CNT_W = 5;

    // Twiddle table: one octant, cos and sin of 2*pi*k/POINTS for k in 0..POINTS/8
    localparam int OCT     = POINTS / 8;
    localparam int QUART   = POINTS / 4;
    localparam int OCT_W   = 8;
    localparam int TWF_W   = TWIDDLE_BITS - 1;

    localparam logic signed [TR_W:0] WORK_LIMIT =
        (TR_W+1)'(longint'(POINTS) << (SAMPLE_BITS - 1));
    localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(longint'(POINTS) << (SAMPLE_BITS - 1));

    localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PAD,
        ST_BR_R0,
        ST_BR_R1,
        ST_BR_W0,
        ST_BR_W1,
        ST_BF_RDB,
        ST_BF_RDA,
        ST_BF_M0,
        ST_BF_M1,
        ST_BF_M2,
        ST_BF_M3,
        ST_BF_M4,
        ST_BF_WA,
        ST_BF_WB,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_SQ0,
        ST_SQ1,
        ST_SQ2,
        ST_SQ_WAIT,
        ST_OUT
    } state_t;

    typedef logic [2*TWF_W-1:0] tw_word_t;
    typedef tw_word_t tw_tab_t [OCT+1];

    function automatic logic [TWF_W-1:0] quant_tw(longint unsigned q30);
        longint unsigned v;
        longint unsigned mx;
        v  = (q30 + (64'd1 << (30 - TWF_W - 1))) >> (30 - TWF_W);
        mx = (64'd1 << TWF_W) - 64'd1;
        if (v > mx)
        begin
            v = mx;
        end
        return TWF_W'(v);
    endfunction

    // Taylor series in Q30, seven terms each, packed as {cos, sin}
    function automatic tw_word_t eval_octant(int k);
        longint unsigned theta;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint unsigned sc;
        longint unsigned ss;
        theta = (PI_Q60 >> (LOG_POINTS - 1)) * longint'(k);
        x  = (theta + (64'd1 << 29)) >> 30;
        x2 = (x * x) >> 30;
        tc = 64'd1 << 30;
        ts = x;
        sc = tc;
        ss = ts;
        tc = ((tc * x2) >> 30) / 2;   ts = ((ts * x2) >> 30) / 6;
        sc = sc - tc;                 ss = ss - ts;
        tc = ((tc * x2) >> 30) / 12;  ts = ((ts * x2) >> 30) / 20;
        sc = sc + tc;                 ss = ss + ts;
        tc = ((tc * x2) >> 30) / 30;  ts = ((ts * x2) >> 30) / 42;
        sc = sc - tc;                 ss = ss - ts;
        tc = ((tc * x2) >> 30) / 56;  ts = ((ts * x2) >> 30) / 72;
        sc = sc + tc;                 ss = ss + ts;
        tc = ((tc * x2) >> 30) / 90;  ts = ((ts * x2) >> 30) / 110;
        sc = sc - tc;                 ss = ss - ts;
        tc = ((tc * x2) >> 30) / 132; ts = ((ts * x2) >> 30) / 156;
        sc = sc + tc;                 ss = ss + ts;
        return {quant_tw(sc), quant_tw(ss)};
    endfunction

    function automatic tw_tab_t build_tw_tab();
        tw_tab_t tab;
        for (int k = 0; k <= OCT; k++)
        begin
            tab[k] = eval_octant(k);
        end
        return tab;
    endfunction

    function automatic logic [ADDR_W-1:0] bit_rev(logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        for (int i = 0; i < ADDR_W; i++)
        begin
            r[i] = v[ADDR_W-1-i];
        end
        return r;
    endfunction

    function automatic logic signed [WORK_W-1:0] sat_work(logic signed [TR_W:0] v);
        logic signed [WORK_W-1:0] r;
        if (v > WORK_LIMIT)
        begin
            r = WORK_W'(WORK_LIMIT);
        end
        else if (v < -WORK_LIMIT)
        begin
            r = WORK_W'(-WORK_LIMIT);
        end
        else
        begin
            r = v[WORK_W-1:0];
        end
        return r;
    endfunction

    // floor((v + half LSB) / 2^(TWIDDLE_BITS-1))
    function automatic logic signed [TR_W-1:0] round_scale(logic signed [PROD_W:0] v);
        logic signed [PROD_W:0] t;
        t = v + (PROD_W+1)'(longint'(1) << (TWIDDLE_BITS - 2));
        t = t >>> TWF_W;
        return t[TR_W-1:0];
    endfunction

endpackage

/* rtl/core/fftm_if.sv */
// ----------------------------------------------------------------------------
// fftm_if: request and response channels of the FFT magnitude core
// Valid/ready channels; a transaction moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface fftm_req_if;
    logic                                     valid;
    logic                                     ready;
    fftm_pkg::op_t                            op;
    logic signed [fftm_pkg::SAMPLE_BITS-1:0]  sample;
    logic                                     last;
    logic [fftm_pkg::BIN_W-1:0]               bin;

    modport source (output valid, op, sample, last, bin, input ready);
    modport sink   (input valid, op, sample, last, bin, output ready);
endinterface

interface fftm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fftm_pkg::MAG_W-1:0]     magnitude;
    logic [fftm_pkg::BIN_W-1:0]     bin_echo;
    logic                           spectrum_ready;

    modport source (output valid, magnitude, bin_echo, spectrum_ready, input ready);
    modport sink   (input valid, magnitude, bin_echo, spectrum_ready, output ready);
endinterface

/* rtl/core/fft_magnitude_spectrum_core.sv */
// ----------------------------------------------------------------------------
// fft_magnitude_spectrum_core: radix-2 FFT magnitude spectrum
// Loads a real frame, runs an in-place DIT FFT and answers bin magnitude reads.
// ----------------------------------------------------------------------------
//
//   channel | dir | fields                                | transaction
//   --------+-----+---------------------------------------+---------------------
//   req     | in  | op, sample, last, bin                 | load sample / read bin
//   rsp     | out | magnitude, bin_echo, spectrum_ready   | one per read
//
// The frame that closes (1024th sample or last) is padded one zero a cycle,
// bit-reverse reordered (two reads, two writes per swapped index) and
// transformed in 5120 butterflies of two reads, four products, two writes;
// one work RAM with a write and a read port and one 27x27 multiplier serve
// every step. A read of a finished spectrum is mostly the 26-step square
// root; other reads return zero. req is not ready while an item is in work;
// a result waits in the output register while rsp stalls. Reset clears the
// sequencer, the load count and the spectrum flag; the work RAM is not cleared.
//
module fft_magnitude_spectrum_core (
    input logic clk,
    input logic rst_n,
    fftm_req_if.sink   req,
    fftm_rsp_if.source rsp
);
    import fftm_pkg::*;

    // work RAM: {re, im} per point
    logic [ENTRY_W-1:0] work_mem [POINTS];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata_reg;

    // sequencer and counters
    state_t             state_reg;
    state_t             state_next;
    logic [ADDR_W-1:0]  load_cnt_reg;
    logic [ADDR_W-1:0]  load_cnt_next;
    logic               spec_valid_reg;
    logic               spec_valid_next;
    logic [ADDR_W-1:0]  br_idx_reg;
    logic [ADDR_W-1:0]  br_idx_next;
    logic [STAGE_W-1:0] stage_reg;
    logic [STAGE_W-1:0] stage_next;
    logic [BF_W-1:0]    bf_idx_reg;
    logic [BF_W-1:0]    bf_idx_next;
    logic               rsp_valid_reg;

    // datapath registers
    logic [ENTRY_W-1:0]       a_reg;
    logic [ENTRY_W-1:0]       a_next;
    logic [ENTRY_W-1:0]       b_reg;
    logic [ENTRY_W-1:0]       b_next;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;
    logic signed [PROD_W-1:0] mul_reg;
    logic signed [TR_W-1:0]   tr_reg;
    logic signed [TR_W-1:0]   tr_next;
    logic signed [TR_W-1:0]   ti_reg;
    logic signed [TR_W-1:0]   ti_next;
    logic [BIN_W-1:0]         bin_reg;
    logic [BIN_W-1:0]         bin_next;
    logic [MAG_W-1:0]         mag_reg;
    logic [MAG_W-1:0]         mag_next;
    logic [MAG_W-1:0]         rsp_mag_reg;
    logic [BIN_W-1:0]         rsp_bin_reg;
    logic                     rsp_rdy_flag_reg;

    // shared multiplier operands
    logic signed [WORK_W-1:0] mul_a;
    logic signed [WORK_W-1:0] mul_b;

    // butterfly addressing
    logic [ADDR_W-1:0]  bf_ext;
    logic [ADDR_W-1:0]  bf_lo_mask;
    logic [ADDR_W-1:0]  bf_addr_a;
    logic [ADDR_W-1:0]  bf_addr_b;
    logic [BF_W-1:0]    tw_idx;
    logic [ADDR_W-1:0]  br_rev;
    logic               br_last;
    logic               bf_last;

    logic signed [TWIDDLE_BITS-1:0] tw_cos;
    logic signed [TWIDDLE_BITS-1:0] tw_sin;
    logic signed [WORK_W-1:0]       c_ext;
    logic signed [WORK_W-1:0]       s_ext;

    logic signed [WORK_W-1:0] a_re;
    logic signed [WORK_W-1:0] a_im;
    logic signed [WORK_W-1:0] b_re;
    logic signed [WORK_W-1:0] b_im;
    logic signed [WORK_W-1:0] rd_re;
    logic signed [WORK_W-1:0] rd_im;
    logic [WORK_W-1:0]        abs_re;
    logic [WORK_W-1:0]        abs_im;
    logic [PROD_W:0]          power_sum;

    logic                     out_load;
    logic                     sq_start;
    logic                     sq_done;
    logic [MAG_W-1:0]         sq_root;

    // split the butterfly index around the current stage bit
    always_comb
    begin
        bf_ext     = {1'b0, bf_idx_reg};
        bf_lo_mask = (ADDR_W'(1) << stage_reg) - ADDR_W'(1);
        bf_addr_a  = ((bf_ext >> stage_reg) << (stage_reg + 1'b1)) | (bf_ext & bf_lo_mask);
        bf_addr_b  = bf_addr_a | (ADDR_W'(1) << stage_reg);
        tw_idx     = BF_W'((bf_ext & bf_lo_mask) << (STAGE_W'(LOG_POINTS - 1) - stage_reg));
    end

    assign br_rev  = bit_rev(br_idx_reg);
    assign br_last = (br_idx_reg == ADDR_W'(POINTS - 1));
    assign bf_last = (bf_idx_reg == BF_W'(HALF - 1));

    fftm_twiddle u_twiddle (
        .clk    (clk),
        .w      (tw_idx),
        .tw_cos (tw_cos),
        .tw_sin (tw_sin)
    );

    assign c_ext = WORK_W'(tw_cos);
    assign s_ext = WORK_W'(tw_sin);

    assign a_re  = a_reg[ENTRY_W-1:WORK_W];
    assign a_im  = a_reg[WORK_W-1:0];
    assign b_re  = b_reg[ENTRY_W-1:WORK_W];
    assign b_im  = b_reg[WORK_W-1:0];
    assign rd_re = mem_rdata_reg[ENTRY_W-1:WORK_W];
    assign rd_im = mem_rdata_reg[WORK_W-1:0];
    assign abs_re = rd_re[WORK_W-1] ? WORK_W'(-rd_re) : WORK_W'(rd_re);
    assign abs_im = rd_im[WORK_W-1] ? WORK_W'(-rd_im) : WORK_W'(rd_im);
    assign power_sum = {1'b0, acc_reg} + {1'b0, mul_reg};

    fftm_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (power_sum[SQ_IN_W-1:0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    // sequencer: next state, RAM port control, multiplier operand select
    always_comb
    begin
        state_next      = state_reg;
        load_cnt_next   = load_cnt_reg;
        spec_valid_next = spec_valid_reg;
        br_idx_next     = br_idx_reg;
        stage_next      = stage_reg;
        bf_idx_next     = bf_idx_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        tr_next         = tr_reg;
        ti_next         = ti_reg;
        bin_next        = bin_reg;
        mag_next        = mag_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;
        mul_a           = '0;
        mul_b           = '0;
        sq_start        = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.op == OP_LOAD)
                    begin
                        // a load overwrites the workspace: drop the spectrum
                        mem_we          = 1'b1;
                        mem_waddr       = load_cnt_reg;
                        mem_wdata       = {WORK_W'(req.sample), {WORK_W{1'b0}}};
                        spec_valid_next = 1'b0;
                        if (load_cnt_reg == ADDR_W'(POINTS - 1))
                        begin
                            load_cnt_next = '0;
                            br_idx_next   = '0;
                            state_next    = ST_BR_R0;
                        end
                        else
                        begin
                            load_cnt_next = load_cnt_reg + 1'b1;
                            if (req.last)
                            begin
                                state_next = ST_PAD;
                            end
                        end
                    end
                    else
                    begin
                        bin_next = req.bin;
                        mag_next = '0;
                        if (spec_valid_reg && ({1'b0, req.bin} < ADDR_W'(HALF)))
                        begin
                            state_next = ST_RD_ADDR;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end

            ST_PAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = load_cnt_reg;
                mem_wdata = '0;
                if (load_cnt_reg == ADDR_W'(POINTS - 1))
                begin
                    load_cnt_next = '0;
                    br_idx_next   = '0;
                    state_next    = ST_BR_R0;
                end
                else
                begin
                    load_cnt_next = load_cnt_reg + 1'b1;
                end
            end

            ST_BR_R0:
            begin
                if (br_rev > br_idx_reg)
                begin
                    mem_raddr  = br_idx_reg;
                    state_next = ST_BR_R1;
                end
                else if (br_last)
                begin
                    stage_next  = '0;
                    bf_idx_next = '0;
                    state_next  = ST_BF_RDB;
                end
                else
                begin
                    br_idx_next = br_idx_reg + 1'b1;
                end
            end

            ST_BR_R1:
            begin
                mem_raddr  = br_rev;
                a_next     = mem_rdata_reg;
                state_next = ST_BR_W0;
            end

            ST_BR_W0:
            begin
                mem_we     = 1'b1;
                mem_waddr  = br_idx_reg;
                mem_wdata  = mem_rdata_reg;
                state_next = ST_BR_W1;
            end

            ST_BR_W1:
            begin
                mem_we    = 1'b1;
                mem_waddr = br_rev;
                mem_wdata = a_reg;
                if (br_last)
                begin
                    stage_next  = '0;
                    bf_idx_next = '0;
                    state_next  = ST_BF_RDB;
                end
                else
                begin
                    br_idx_next = br_idx_reg + 1'b1;
                    state_next  = ST_BR_R0;
                end
            end

            ST_BF_RDB:
            begin
                mem_raddr  = bf_addr_b;
                state_next = ST_BF_RDA;
            end

            ST_BF_RDA:
            begin
                mem_raddr  = bf_addr_a;
                b_next     = mem_rdata_reg;
                state_next = ST_BF_M0;
            end

            ST_BF_M0:
            begin
                a_next     = mem_rdata_reg;
                mul_a      = c_ext;
                mul_b      = b_re;
                state_next = ST_BF_M1;
            end

            ST_BF_M1:
            begin
                acc_next   = mul_reg;
                mul_a      = s_ext;
                mul_b      = b_im;
                state_next = ST_BF_M2;
            end

            ST_BF_M2:
            begin
                tr_next    = round_scale((PROD_W+1)'(acc_reg) + (PROD_W+1)'(mul_reg));
                mul_a      = c_ext;
                mul_b      = b_im;
                state_next = ST_BF_M3;
            end

            ST_BF_M3:
            begin
                acc_next   = mul_reg;
                mul_a      = s_ext;
                mul_b      = b_re;
                state_next = ST_BF_M4;
            end

            ST_BF_M4:
            begin
                ti_next    = round_scale((PROD_W+1)'(acc_reg) - (PROD_W+1)'(mul_reg));
                state_next = ST_BF_WA;
            end

            ST_BF_WA:
            begin
                mem_we     = 1'b1;
                mem_waddr  = bf_addr_a;
                mem_wdata  = {sat_work((TR_W+1)'(a_re) + (TR_W+1)'(tr_reg)),
                              sat_work((TR_W+1)'(a_im) + (TR_W+1)'(ti_reg))};
                state_next = ST_BF_WB;
            end

            ST_BF_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = bf_addr_b;
                mem_wdata = {sat_work((TR_W+1)'(a_re) - (TR_W+1)'(tr_reg)),
                             sat_work((TR_W+1)'(a_im) - (TR_W+1)'(ti_reg))};
                state_next = ST_BF_RDB;
                if (bf_last)
                begin
                    bf_idx_next = '0;
                    if (stage_reg == STAGE_W'(LOG_POINTS - 1))
                    begin
                        spec_valid_next = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        stage_next = stage_reg + 1'b1;
                    end
                end
                else
                begin
                    bf_idx_next = bf_idx_reg + 1'b1;
                end
            end

            ST_RD_ADDR:
            begin
                mem_raddr  = {1'b0, bin_reg};
                state_next = ST_RD_DATA;
            end

            ST_RD_DATA:
            begin
                b_next     = {abs_re, abs_im};
                state_next = ST_SQ0;
            end

            ST_SQ0:
            begin
                mul_a      = b_re;
                mul_b      = b_re;
                state_next = ST_SQ1;
            end

            ST_SQ1:
            begin
                acc_next   = mul_reg;
                mul_a      = b_im;
                mul_b      = b_im;
                state_next = ST_SQ2;
            end

            ST_SQ2:
            begin
                sq_start   = 1'b1;
                state_next = ST_SQ_WAIT;
            end

            ST_SQ_WAIT:
            begin
                if (sq_done)
                begin
                    mag_next   = (sq_root > MAG_CAP) ? MAG_CAP : sq_root;
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_cnt_reg   <= '0;
            spec_valid_reg <= 1'b0;
            br_idx_reg     <= '0;
            stage_reg      <= '0;
            bf_idx_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_cnt_reg   <= load_cnt_next;
            spec_valid_reg <= spec_valid_next;
            br_idx_reg     <= br_idx_next;
            stage_reg      <= stage_next;
            bf_idx_reg     <= bf_idx_next;
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        tr_reg  <= tr_next;
        ti_reg  <= ti_next;
        bin_reg <= bin_next;
        mag_reg <= mag_next;
        mul_reg <= mul_a * mul_b;
        if (out_load)
        begin
            rsp_mag_reg      <= mag_reg;
            rsp_bin_reg      <= bin_reg;
            rsp_rdy_flag_reg <= spec_valid_reg;
        end
    end

    // work RAM: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            work_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= work_mem[mem_raddr];
    end

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.magnitude      = rsp_mag_reg;
    assign rsp.bin_echo       = rsp_bin_reg;
    assign rsp.spectrum_ready = rsp_rdy_flag_reg;

endmodule

/* rtl/core/fftm_twiddle.sv */
// ----------------------------------------------------------------------------
// fftm_twiddle: twiddle factor lookup
// One-octant Q1.15 table with symmetry mapping; registered read.
// ----------------------------------------------------------------------------
module fftm_twiddle (
    input  logic                                   clk,
    input  logic [fftm_pkg::BF_W-1:0]              w,
    output logic signed [fftm_pkg::TWIDDLE_BITS-1:0] tw_cos,
    output logic signed [fftm_pkg::TWIDDLE_BITS-1:0] tw_sin
);
    import fftm_pkg::*;

    localparam tw_tab_t TW_TAB = build_tw_tab();

    logic [ADDR_W-1:0] w_ext;
    logic [ADDR_W-1:0] m;
    logic [OCT_W-1:0]  idx;
    logic              swap;
    logic              neg;
    tw_word_t          rom_reg;
    logic              swap_reg;
    logic              neg_reg;
    logic [TWF_W-1:0]  cos_mag;
    logic [TWF_W-1:0]  sin_mag;

    // fold the half circle onto the first octant
    always_comb
    begin
        w_ext = {1'b0, w};
        m     = ADDR_W'(HALF) - w_ext;
        swap  = 1'b0;
        neg   = 1'b0;
        if (w_ext <= ADDR_W'(OCT))
        begin
            idx = w_ext[OCT_W-1:0];
        end
        else if (w_ext <= ADDR_W'(QUART))
        begin
            idx  = OCT_W'(ADDR_W'(QUART) - w_ext);
            swap = 1'b1;
        end
        else if (m <= ADDR_W'(OCT))
        begin
            idx = m[OCT_W-1:0];
            neg = 1'b1;
        end
        else
        begin
            idx  = OCT_W'(ADDR_W'(QUART) - m);
            swap = 1'b1;
            neg  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rom_reg  <= TW_TAB[idx];
        swap_reg <= swap;
        neg_reg  <= neg;
    end

    assign cos_mag = swap_reg ? rom_reg[TWF_W-1:0] : rom_reg[2*TWF_W-1:TWF_W];
    assign sin_mag = swap_reg ? rom_reg[2*TWF_W-1:TWF_W] : rom_reg[TWF_W-1:0];
    assign tw_cos  = neg_reg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    assign tw_sin  = $signed({1'b0, sin_mag});

endmodule

/* rtl/core/fftm_isqrt.sv */
// ----------------------------------------------------------------------------
// fftm_isqrt: iterative integer square root
// Digit-by-digit, one result bit per cycle; floor of the square root.
// ----------------------------------------------------------------------------
module fftm_isqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [fftm_pkg::SQ_IN_W-1:0]     value,
    output logic                             done,
    output logic [fftm_pkg::MAG_W-1:0]       root
);
    import fftm_pkg::*;

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [SQ_CNT_W-1:0] cnt_next;
    logic [SQ_IN_W-1:0]  rem_reg;
    logic [SQ_IN_W-1:0]  rem_next;
    logic [SQ_IN_W-1:0]  res_reg;
    logic [SQ_IN_W-1:0]  res_next;
    logic [SQ_IN_W-1:0]  bit_reg;
    logic [SQ_IN_W-1:0]  bit_next;
    logic [SQ_IN_W-1:0]  trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        trial     = res_reg + bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = value;
            res_next  = '0;
            bit_next  = SQ_IN_W'(1) << (SQ_IN_W - 2);
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SQ_CNT_W'(SQ_ITER - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[MAG_W-1:0];

endmodule

/* rtl/core/fftm_checker.sv */
// ----------------------------------------------------------------------------
// fftm_checker: port-level assertions of the FFT magnitude core
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module fftm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input fftm_pkg::op_t                 req_op,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [fftm_pkg::MAG_W-1:0]    magnitude,
    input logic [fftm_pkg::BIN_W-1:0]    bin_echo,
    input logic                          spectrum_ready
);
    import fftm_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(magnitude) && $stable(bin_echo))
        else $error("response dropped or changed while stalled");

    a_rsp_flag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(spectrum_ready))
        else $error("spectrum_ready changed while stalled");

    // no spectrum means no magnitude
    a_no_spec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !spectrum_ready |-> magnitude == '0)
        else $error("magnitude without a finished spectrum");

    a_mag_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> magnitude <= MAG_CAP)
        else $error("magnitude above saturation limit");

    // a read transaction leaves the core busy in the next cycle
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_op == OP_READ |=> !req_ready)
        else $error("request ready right after a read");

endmodule

bind fft_magnitude_spectrum_core fftm_checker u_fftm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_op         (req.op),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .magnitude      (rsp.magnitude),
    .bin_echo       (rsp.bin_echo),
    .spectrum_ready (rsp.spectrum_ready)
);

/* dv/tb_fft_magnitude_spectrum_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fft_magnitude_spectrum_core: self-checking bench of the FFT magnitude core
// Frames of signed samples go in over req. A bit-exact fixed-point FFT kept in
// the bench predicts every bin read, and each rsp transaction is checked
// against the oldest prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_fft_magnitude_spectrum_core;
    import fftm_pkg::*;

    typedef struct {
        op_t                     op;
        logic [SAMPLE_BITS-1:0]  sample;
        logic                    last;
        logic [BIN_W-1:0]        bin;
    } req_item_t;

    typedef struct {
        logic [MAG_W-1:0] magnitude;
        logic [BIN_W-1:0] bin_echo;
        logic             spectrum_ready;
    } mag_result_t;

    localparam longint SPEC_LIMIT = longint'(POINTS) << (SAMPLE_BITS - 1);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fftm_req_if req_ch ();
    fftm_rsp_if rsp_ch ();

    fft_magnitude_spectrum_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #10 clk = ~clk;

    // Pending stimulus and the magnitudes still owed by the core.
    req_item_t   pend_q[$];
    mag_result_t mag_expect_q[$];
    int          err_cnt = 0;
    int          sent_cnt = 0;
    int          total_items = 1;

    // Bench copy of the spectrum workspace and its twiddle table.
    longint      spec_re[POINTS];
    longint      spec_im[POINTS];
    longint      tw_cos[HALF];
    longint      tw_sin[HALF];
    int          fill_cnt = 0;
    bit          have_spectrum = 1'b0;

    // ------------------------------------------------------------------------
    // Twiddles: Q30 Taylor series over one octant, then exact symmetry.
    // ------------------------------------------------------------------------
    function automatic longint to_twiddle(longint unsigned q30);
        longint unsigned v;
        v = (q30 + (64'd1 << (30 - TWIDDLE_BITS))) >> (31 - TWIDDLE_BITS);
        if (v > (64'd1 << (TWIDDLE_BITS - 1)) - 1)
        begin
            v = (64'd1 << (TWIDDLE_BITS - 1)) - 1;
        end
        return longint'(v);
    endfunction

    task automatic octant_point(input int k, output longint c, output longint s);
        longint unsigned ang;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint unsigned sc;
        longint unsigned ss;
        ang = (PI_Q60 >> (LOG_POINTS - 1)) * longint'(k);
        x  = (ang + (64'd1 << 29)) >> 30;
        x2 = (x * x) >> 30;
        tc = 64'd1 << 30;
        ts = x;
        sc = tc;
        ss = ts;
        for (int n = 1; n <= 6; n++)
        begin
            tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                sc = sc - tc;
                ss = ss - ts;
            end
            else
            begin
                sc = sc + tc;
                ss = ss + ts;
            end
        end
        c = to_twiddle(sc);
        s = to_twiddle(ss);
    endtask

    task automatic fill_twiddles();
        longint a;
        longint b;
        int     m;
        for (int k = 0; k < HALF; k++)
        begin
            m = (k <= QUART) ? k : HALF - k;
            if (m <= OCT)
            begin
                octant_point(m, a, b);
            end
            else
            begin
                octant_point(QUART - m, b, a);
            end
            tw_cos[k] = (k <= QUART) ? a : -a;
            tw_sin[k] = b;
        end
    endtask

    function automatic longint clamp_work(longint v);
        if (v > SPEC_LIMIT)
        begin
            return SPEC_LIMIT;
        end
        if (v < -SPEC_LIMIT)
        begin
            return -SPEC_LIMIT;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // In-place transform: bit-reverse reorder, then radix-2 DIT butterflies
    // with products rounded half up and every stored value clamped.
    // ------------------------------------------------------------------------
    task automatic run_fft();
        int     j;
        int     half_len;
        int     w;
        longint t;
        longint tr;
        longint ti;
        longint ar;
        longint ai;
        for (int i = 0; i < POINTS; i++)
        begin
            j = 0;
            for (int b = 0; b < LOG_POINTS; b++)
            begin
                j |= ((i >> b) & 1) << (LOG_POINTS - 1 - b);
            end
            if (j > i)
            begin
                t = spec_re[i]; spec_re[i] = spec_re[j]; spec_re[j] = t;
                t = spec_im[i]; spec_im[i] = spec_im[j]; spec_im[j] = t;
            end
        end
        for (int len = 2; len <= POINTS; len = len * 2)
        begin
            half_len = len / 2;
            for (int i = 0; i < POINTS; i += len)
            begin
                for (int k = 0; k < half_len; k++)
                begin
                    w  = (k * (POINTS / len)) & (HALF - 1);
                    tr = (tw_cos[w] * spec_re[i+k+half_len] + tw_sin[w] * spec_im[i+k+half_len]
                          + (longint'(1) << (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
                    ti = (tw_cos[w] * spec_im[i+k+half_len] - tw_sin[w] * spec_re[i+k+half_len]
                          + (longint'(1) << (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
                    ar = spec_re[i+k];
                    ai = spec_im[i+k];
                    spec_re[i+k]          = clamp_work(ar + tr);
                    spec_im[i+k]          = clamp_work(ai + ti);
                    spec_re[i+k+half_len] = clamp_work(ar - tr);
                    spec_im[i+k+half_len] = clamp_work(ai - ti);
                end
            end
        end
    endtask

    function automatic longint bin_root(int b);
        longint unsigned ar;
        longint unsigned ai;
        longint unsigned pwr;
        longint unsigned r;
        longint unsigned trial;
        ar  = (spec_re[b] < 0) ? -spec_re[b] : spec_re[b];
        ai  = (spec_im[b] < 0) ? -spec_im[b] : spec_im[b];
        pwr = ar * ar + ai * ai;
        r   = 0;
        for (int k = 31; k >= 0; k--)
        begin
            trial = r | (64'd1 << k);
            if (trial * trial <= pwr)
            begin
                r = trial;
            end
        end
        return (r > SPEC_LIMIT) ? SPEC_LIMIT : longint'(r);
    endfunction

    // Advance the bench spectrum by one accepted request transaction.
    task automatic apply_request(input req_item_t it);
        mag_result_t res;
        if (it.op == OP_LOAD)
        begin
            have_spectrum = 1'b0;
            if (fill_cnt >= POINTS)
            begin
                fill_cnt = 0;
            end
            spec_re[fill_cnt] = longint'($signed(it.sample));
            spec_im[fill_cnt] = 0;
            fill_cnt++;
            if (it.last || fill_cnt >= POINTS)
            begin
                // zero-pad the tail, then transform the closed frame
                while (fill_cnt < POINTS)
                begin
                    spec_re[fill_cnt] = 0;
                    spec_im[fill_cnt] = 0;
                    fill_cnt++;
                end
                run_fft();
                have_spectrum = 1'b1;
                fill_cnt = 0;
            end
        end
        else
        begin
            res.magnitude      = (have_spectrum && it.bin < HALF) ? MAG_W'(bin_root(it.bin)) : '0;
            res.bin_echo       = it.bin;
            res.spectrum_ready = have_spectrum;
            mag_expect_q       = {mag_expect_q, res};
        end
    endtask

    task automatic report_mismatch(input string field, input longint exp_v, input longint got_v);
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, field, exp_v, got_v);
        err_cnt++;
    endtask

    // Idle percentages follow the run phase: none, sender, receiver, both.
    function automatic int send_idle_pct();
        case (sent_cnt * 4 / total_items)
            1: return 77;
            3: return 35;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (sent_cnt * 4 / total_items)
            2: return 77;
            3: return 35;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: predict on each accepted transaction, then present the next one.
    // ------------------------------------------------------------------------
    req_item_t drv_item;

    initial
    begin
        req_ch.valid  = 1'b0;
        req_ch.op     = OP_LOAD;
        req_ch.sample = '0;
        req_ch.last   = 1'b0;
        req_ch.bin    = '0;
        rsp_ch.ready  = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                apply_request(drv_item);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct())
                begin
                    drv_item = pend_q.pop_front();
                    sent_cnt++;
                    req_ch.op     <= drv_item.op;
                    req_ch.sample <= drv_item.sample;
                    req_ch.last   <= drv_item.last;
                    req_ch.bin    <= drv_item.bin;
                    req_ch.valid  <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each response transaction, then pick the next ready.
    // ------------------------------------------------------------------------
    mag_result_t mon_exp;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (mag_expect_q.size() == 0)
                begin
                    report_mismatch("unexpected response, bin_echo", -1, rsp_ch.bin_echo);
                end
                else
                begin
                    mon_exp = mag_expect_q.pop_front();
                    if (rsp_ch.magnitude !== mon_exp.magnitude)
                    begin
                        report_mismatch("magnitude", mon_exp.magnitude, rsp_ch.magnitude);
                    end
                    if (rsp_ch.bin_echo !== mon_exp.bin_echo)
                    begin
                        report_mismatch("bin_echo", mon_exp.bin_echo, rsp_ch.bin_echo);
                    end
                    if (rsp_ch.spectrum_ready !== mon_exp.spectrum_ready)
                    begin
                        report_mismatch("spectrum_ready", mon_exp.spectrum_ready,
                                        rsp_ch.spectrum_ready);
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct());
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_load(input logic [SAMPLE_BITS-1:0] s, input logic lst);
        req_item_t it;
        it.op     = OP_LOAD;
        it.sample = s;
        it.last   = lst;
        it.bin    = BIN_W'($urandom);
        pend_q    = {pend_q, it};
    endtask

    task automatic push_read(input logic [BIN_W-1:0] b, input logic lst);
        req_item_t it;
        it.op     = OP_READ;
        it.sample = SAMPLE_BITS'($urandom);
        it.last   = lst;
        it.bin    = b;
        pend_q    = {pend_q, it};
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(3))
            0: return SAMPLE_BITS'($urandom);
            1: return SAMPLE_BITS'($urandom_range(15)) - SAMPLE_BITS'(8);
            2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return SAMPLE_BITS'($urandom_range(2047)) - SAMPLE_BITS'(1024);
        endcase
    endfunction

    initial
    begin
        int flen;
        int nreads;

        fill_twiddles();

        // Directed: reads before any spectrum, a short frame of extremes,
        // edge bins, and a read while the next frame is loading.
        push_read(0, 1'b0);
        push_read(BIN_W'(HALF - 1), 1'b1);
        push_load(16'sh7FFF, 1'b0);
        push_load(16'sh8000, 1'b0);
        push_load(16'sh0000, 1'b0);
        push_load(16'sh0001, 1'b0);
        push_load(16'shFFFF, 1'b0);
        push_load(16'sh5555, 1'b1);
        push_read(0, 1'b0);
        push_read(1, 1'b1);
        push_read(2, 1'b0);
        push_read(3, 1'b0);
        push_read(BIN_W'(HALF - 1), 1'b0);
        push_read(9'h155, 1'b0);
        push_load(16'sh2AAA, 1'b0);
        push_read(5, 1'b0);
        push_load(16'shD555, 1'b1);
        push_read(1, 1'b0);
        push_read(9'h0AA, 1'b1);

        // A full frame of the most negative sample closes on the count alone
        // and drives bin 0 close to the saturation limit.
        for (int i = 0; i < POINTS; i++)
        begin
            push_load(16'sh8000, 1'b0);
            if (i == 3)
            begin
                push_read(0, 1'b0);
            end
        end
        push_read(0, 1'b0);
        for (int i = 0; i < 20; i++)
        begin
            push_read(BIN_W'($urandom), 1'(i));
        end

        // Random frames: short loads with random content, the odd read while
        // loading, then a burst of reads.
        while (pend_q.size() < 1250)
        begin
            flen = ($urandom_range(9) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 24);
            for (int i = 0; i < flen; i++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    push_read(BIN_W'($urandom), 1'($urandom));
                end
                push_load(pick_sample(), i == flen - 1);
            end
            nreads = $urandom_range(15, 35);
            for (int i = 0; i < nreads; i++)
            begin
                push_read($urandom_range(1) ? BIN_W'($urandom) : BIN_W'($urandom_range(15)),
                          1'($urandom));
            end
        end
        total_items = pend_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all stimulus out, all responses in, then a short settle.
        while (pend_q.size() > 0 || req_ch.valid || mag_expect_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);

        if (err_cnt == 0 && mag_expect_q.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #80000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/core/fftm_pkg.sv
rtl/core/fftm_if.sv
rtl/core/fftm_twiddle.sv
rtl/core/fftm_isqrt.sv
rtl/core/fft_magnitude_spectrum_core.sv
rtl/core/fftm_checker.sv
dv/tb_fft_magnitude_spectrum_core.sv
